FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the quaternion rotation pipeline.
// Needs nothing else; each user passes its own clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define QRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrv: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define QRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrv: next-cycle check failed");

`endif

FILE: rtl/core/qrv_pkg.sv
// Shared widths and transaction types for the quaternion rotation pipeline.
// No dependencies.
package qrv_pkg;

    localparam int QUAT_W  = 16;               // Q2.14 quaternion component
    localparam int VEC_W   = 24;               // vector / result component
    localparam int QPROD_W = 2 * QUAT_W;       // quaternion component product
    localparam int MAT_W   = QPROD_W + 2;      // rotation matrix entry, Q6.28
    localparam int PROD_W  = MAT_W + VEC_W;    // matrix entry times vector component
    localparam int SUM_W   = PROD_W + 2;       // sum of three products
    localparam int FRAC_W  = 28;               // fraction bits dropped at the end
    localparam int RES_W   = SUM_W - FRAC_W;   // scaled result before clamping

    // Input transaction
    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [VEC_W-1:0]  vec_x;
        logic signed [VEC_W-1:0]  vec_y;
        logic signed [VEC_W-1:0]  vec_z;
    } t_in_item;

    // Vector carried alongside the matrix stages
    typedef struct packed {
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
    } t_vec;

    // Output transaction
    typedef struct packed {
        logic signed [VEC_W-1:0] rot_x;
        logic signed [VEC_W-1:0] rot_y;
        logic signed [VEC_W-1:0] rot_z;
        logic                    saturated;
    } t_out_item;

endpackage

FILE: rtl/core/qrv_matrix.sv
// Stages 1-2: quaternion component products, then the rotation matrix R(q).
// Depends on qrv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qrv_matrix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  qrv_pkg::t_in_item                   i_item,
    output logic                                o_valid,
    output qrv_pkg::t_vec                       o_vec,
    output logic signed [qrv_pkg::MAT_W-1:0]    o_mat [9]
);

    localparam int QP = qrv_pkg::QPROD_W;
    localparam int MW = qrv_pkg::MAT_W;

    // stage 1 registers
    logic                 r_v1;
    qrv_pkg::t_vec        r_vec1;
    logic signed [QP-1:0] r_xx, r_yy, r_zz, r_ww;
    logic signed [QP-1:0] r_xy, r_xz, r_yz;
    logic signed [QP-1:0] r_wx, r_wy, r_wz;

    // stage 2 registers
    logic                 r_v2;
    qrv_pkg::t_vec        r_vec2;
    logic signed [MW-1:0] r_mat [9];
    logic signed [MW-1:0] n_mat [9];

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // stage 1: the ten distinct component products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx         <= i_item.quat_x * i_item.quat_x;
            r_yy         <= i_item.quat_y * i_item.quat_y;
            r_zz         <= i_item.quat_z * i_item.quat_z;
            r_ww         <= i_item.quat_w * i_item.quat_w;
            r_xy         <= i_item.quat_x * i_item.quat_y;
            r_xz         <= i_item.quat_x * i_item.quat_z;
            r_yz         <= i_item.quat_y * i_item.quat_z;
            r_wx         <= i_item.quat_w * i_item.quat_x;
            r_wy         <= i_item.quat_w * i_item.quat_y;
            r_wz         <= i_item.quat_w * i_item.quat_z;
            r_vec1.vec_x <= i_item.vec_x;
            r_vec1.vec_y <= i_item.vec_y;
            r_vec1.vec_z <= i_item.vec_z;
        end
    end

    // stage 2: matrix entries, row major
    always_comb begin
        n_mat[0] = MW'(r_ww) + MW'(r_xx) - MW'(r_yy) - MW'(r_zz);
        n_mat[1] = (MW'(r_xy) - MW'(r_wz)) <<< 1;
        n_mat[2] = (MW'(r_xz) + MW'(r_wy)) <<< 1;
        n_mat[3] = (MW'(r_xy) + MW'(r_wz)) <<< 1;
        n_mat[4] = MW'(r_ww) - MW'(r_xx) + MW'(r_yy) - MW'(r_zz);
        n_mat[5] = (MW'(r_yz) - MW'(r_wx)) <<< 1;
        n_mat[6] = (MW'(r_xz) - MW'(r_wy)) <<< 1;
        n_mat[7] = (MW'(r_yz) + MW'(r_wx)) <<< 1;
        n_mat[8] = MW'(r_ww) - MW'(r_xx) - MW'(r_yy) + MW'(r_zz);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mat  <= n_mat;
            r_vec2 <= r_vec1;
        end
    end

    assign o_valid = r_v2;
    assign o_vec   = r_vec2;
    assign o_mat   = r_mat;

    // a valid transaction moves one stage per enabled cycle and holds when stalled
    `QRV_ASSERT_NXT(a_mat_advance, i_clk, i_rst_n, i_en && r_v1, r_v2)
    `QRV_ASSERT_NXT(a_mat_hold, i_clk, i_rst_n, !i_en && r_v2, r_v2)

endmodule

FILE: rtl/core/qrv_mac.sv
// Stages 3-4: matrix-vector products, then row sums with the rounding half.
// Depends on qrv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qrv_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  qrv_pkg::t_vec                       i_vec,
    input  logic signed [qrv_pkg::MAT_W-1:0]    i_mat [9],
    output logic                                o_valid,
    output logic signed [qrv_pkg::SUM_W-1:0]    o_sum [3]
);

    localparam int VW = qrv_pkg::VEC_W;
    localparam int PW = qrv_pkg::PROD_W;
    localparam int SW = qrv_pkg::SUM_W;
    localparam int FW = qrv_pkg::FRAC_W;

    // one half LSB of the scaled result, for round to nearest, ties up
    localparam logic signed [SW-1:0] RoundHalf =
        {{(SW-FW){1'b0}}, 1'b1, {(FW-1){1'b0}}};

    logic signed [VW-1:0] w_vc [3];
    logic                 r_v3;
    logic signed [PW-1:0] r_prod [9];
    logic                 r_v4;
    logic signed [SW-1:0] r_sum [3];
    logic signed [SW-1:0] n_sum [3];

    assign w_vc[0] = i_vec.vec_x;
    assign w_vc[1] = i_vec.vec_y;
    assign w_vc[2] = i_vec.vec_z;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    // stage 3: nine products R_ij * v_j
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[3*i+j] <= i_mat[3*i+j] * w_vc[j];
                end
            end
        end
    end

    // stage 4: row sums plus rounding half
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = SW'(r_prod[3*i]) + SW'(r_prod[3*i+1]) + SW'(r_prod[3*i+2])
                     + RoundHalf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_v4;
    assign o_sum   = r_sum;

    // a stalled transaction in the sum stage stays put
    `QRV_ASSERT_NXT(a_mac_hold, i_clk, i_rst_n, !i_en && r_v4, r_v4)

endmodule

FILE: rtl/core/qrv_round.sv
// Stage 5: drop the fraction bits, clamp to the 24-bit range, flag clipping.
// Depends on qrv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qrv_round (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [qrv_pkg::SUM_W-1:0]    i_sum [3],
    output logic                                o_valid,
    output qrv_pkg::t_out_item                  o_item
);

    localparam int VW = qrv_pkg::VEC_W;
    localparam int SW = qrv_pkg::SUM_W;
    localparam int FW = qrv_pkg::FRAC_W;
    localparam int RW = qrv_pkg::RES_W;

    localparam logic signed [RW-1:0] OutMax = RW'((2 ** (VW - 1)) - 1);
    localparam logic signed [RW-1:0] OutMin = RW'(-(2 ** (VW - 1)));
    localparam logic signed [VW-1:0] LimMax = VW'((2 ** (VW - 1)) - 1);
    localparam logic signed [VW-1:0] LimMin = VW'(-(2 ** (VW - 1)));

    logic signed [RW-1:0] w_res [3];
    logic signed [VW-1:0] w_clamp [3];
    logic [2:0]           w_clip;
    logic                 r_valid;
    qrv_pkg::t_out_item   r_item;
    qrv_pkg::t_out_item   n_item;

    // floor shift (rounding half already added), then clamp each component
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_res[i] = i_sum[i][SW-1:FW];
            if (w_res[i] > OutMax) begin
                w_clamp[i] = LimMax;
                w_clip[i]  = 1'b1;
            end else if (w_res[i] < OutMin) begin
                w_clamp[i] = LimMin;
                w_clip[i]  = 1'b1;
            end else begin
                w_clamp[i] = w_res[i][VW-1:0];
                w_clip[i]  = 1'b0;
            end
        end
        n_item.rot_x     = w_clamp[0];
        n_item.rot_y     = w_clamp[1];
        n_item.rot_z     = w_clamp[2];
        n_item.saturated = |w_clip;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // a flagged result has at least one component sitting on a limit
    `QRV_ASSERT_IMP(a_sat_at_limit, i_clk, i_rst_n, r_valid && r_item.saturated, r_item.rot_x == LimMax || r_item.rot_x == LimMin || r_item.rot_y == LimMax || r_item.rot_y == LimMin || r_item.rot_z == LimMax || r_item.rot_z == LimMin)

endmodule

FILE: rtl/core/quaternion_rotate_vector.sv
// Rotates a 24-bit vector by a Q2.14 quaternion: q * (v,0) * conj(q), saturated.
// Stage order: products, R(q), R*v, row sums, clamp; output stalls delay results.
// Throughput: one transaction per cycle; five register stages advance together
// and all hold while a finished result waits at the output register.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
// Depends on qrv_pkg, qrv_matrix, qrv_mac and qrv_round.
module quaternion_rotate_vector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  qrv_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output qrv_pkg::t_out_item o_out_data
);

    logic                              w_en;
    logic                              w_mat_valid;
    qrv_pkg::t_vec                     w_vec;
    logic signed [qrv_pkg::MAT_W-1:0]  w_mat [9];
    logic                              w_sum_valid;
    logic signed [qrv_pkg::SUM_W-1:0]  w_sum [3];

    // whole pipe advances unless a result sits unclaimed at the output
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    qrv_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_valid (w_mat_valid),
        .o_vec   (w_vec),
        .o_mat   (w_mat)
    );

    qrv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mat_valid),
        .i_vec   (w_vec),
        .i_mat   (w_mat),
        .o_valid (w_sum_valid),
        .o_sum   (w_sum)
    );

    qrv_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sum_valid),
        .i_sum   (w_sum),
        .o_valid (o_out_valid),
        .o_item  (o_out_data)
    );

endmodule
